/* hw/rtl/keyed_index_with_free_slot_stack_core_defines.svh */
// ----------------------------------------------------------------------------
// Keyed index core assertion macros
// Shared concurrent assertion forms, sampled on clk_i, off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef KEYED_INDEX_WITH_FREE_SLOT_STACK_CORE_DEFINES_SVH
`define KEYED_INDEX_WITH_FREE_SLOT_STACK_CORE_DEFINES_SVH

// condition holds at every edge
`define KIFS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the cycle after antecedent
`define KIFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/kifs_pkg.sv */
// ----------------------------------------------------------------------------
// kifs_pkg
// Types and constants shared by the keyed index controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kifs_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned KEY_W   = 31;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned OFF_W   = 32;
  localparam int unsigned SIZE_W  = 10;

  localparam logic [SIZE_W-1:0] FIXED_BYTES  = SIZE_W'(20);
  localparam logic [OFF_W-1:0]  RESET_OFFSET = OFF_W'(4);

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_SCAN,
    CTL_DECIDE
  } ctl_state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
  } ctl_cmd_t;

  typedef struct packed {
    logic match;
    logic scan_end;
    logic used_zero;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/kifs_ctrl.sv */
// ----------------------------------------------------------------------------
// kifs_ctrl
// Sequencer: load the word, scan the table unless it was never filled, then resolve the command.
// ----------------------------------------------------------------------------
`default_nettype none

module kifs_ctrl import kifs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output logic     busy_o,
  output ctl_cmd_t ctl_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    busy_o  = (state_q != CTL_IDLE);
    unique case (state_q)
      CTL_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d    = stat_i.used_zero ? CTL_DECIDE : CTL_SCAN;
        end
      end
      CTL_SCAN: begin
        ctl_o.scan = 1'b1;
        if (stat_i.match || stat_i.scan_end) begin
          state_d = CTL_DECIDE;
        end
      end
      CTL_DECIDE: begin
        ctl_o.decide = 1'b1;
        state_d      = CTL_IDLE;
      end
      default: begin
        state_d = CTL_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/kifs_datapath.sv */
// ----------------------------------------------------------------------------
// kifs_datapath
// Slot table and free-slot link memories, scan pipeline, stack and offset regs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_index_with_free_slot_stack_core_defines.svh"

module kifs_datapath import kifs_pkg::*; #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctl_cmd_t            ctl_i,
  output dp_stat_t            stat_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [LEN_W-1:0]    name_len_i,
  input  logic [LEN_W-1:0]    surname_len_i,
  input  logic [LEN_W-1:0]    course_len_i,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic [SLOT_W-1:0]   slot_o,
  output logic [OFF_W-1:0]    offset_o
);

  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned CW    = SW + 1;
  localparam int unsigned ENT_W = 1 + KEY_W + OFF_W;
  localparam logic [CW-1:0] SlotsC = CW'(SLOTS);

  // entry: valid, key, offset
  logic [ENT_W-1:0] ent_mem  [SLOTS];
  logic [CW-1:0]    link_mem [SLOTS];

  logic [CMD_W-1:0]  cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [SIZE_W-1:0] size_q;
  logic [SW-1:0]     paddr_q;
  logic [SW-1:0]     hit_slot_q;
  logic [OFF_W-1:0]  hit_off_q;
  logic [CW-1:0]     link_rd_q;
  logic [ENT_W-1:0]  ent_rd_q;
  status_e           status_q;
  logic [SLOT_W-1:0] slot_q;
  logic [OFF_W-1:0]  off_q;

  logic [CW-1:0]     scan_q, scan_d;
  logic              pend_q, pend_d;
  logic              last_q, last_d;
  logic              found_q, found_d;
  logic [CW-1:0]     free_top_q, free_top_d;
  logic [CW-1:0]     used_q, used_d;
  logic [OFF_W-1:0]  end_off_q, end_off_d;
  logic              done_q;

  logic              issue, match, stack_empty, table_full, link_re;
  logic              ent_we, link_we;
  logic [SW-1:0]     ent_wa, new_slot, res_slot;
  logic [ENT_W-1:0]  ent_wd;
  logic [OFF_W:0]    next_off;
  logic [OFF_W-1:0]  res_off;
  status_e           res_st;

  assign issue       = ctl_i.scan && (scan_q < used_q);
  assign match       = pend_q && ent_rd_q[ENT_W-1] && (ent_rd_q[OFF_W +: KEY_W] == key_q);
  assign stack_empty = (free_top_q >= SlotsC);
  assign table_full  = stack_empty && (used_q >= SlotsC);
  assign link_re     = ctl_i.load && !stack_empty;
  assign new_slot    = stack_empty ? used_q[SW-1:0] : free_top_q[SW-1:0];
  assign next_off    = {1'b0, end_off_q} + (OFF_W+1)'(size_q);

  assign stat_o.match     = match;
  assign stat_o.scan_end  = pend_q && last_q;
  assign stat_o.used_zero = (used_q == '0);

  always_comb begin
    scan_d     = scan_q;
    pend_d     = pend_q;
    last_d     = last_q;
    found_d    = found_q;
    free_top_d = free_top_q;
    used_d     = used_q;
    end_off_d  = end_off_q;
    ent_we     = 1'b0;
    ent_wa     = new_slot;
    ent_wd     = {1'b1, key_q, end_off_q};
    link_we    = 1'b0;
    res_st     = ST_NOTFOUND;
    res_slot   = '0;
    res_off    = '0;
    if (ctl_i.load) begin
      scan_d  = '0;
      pend_d  = 1'b0;
      last_d  = 1'b0;
      found_d = 1'b0;
    end
    if (ctl_i.scan) begin
      pend_d = issue;
      last_d = issue && (scan_q == (used_q - CW'(1)));
      if (issue) begin
        scan_d = scan_q + CW'(1);
      end
      if (match) begin
        found_d = 1'b1;
      end
    end
    if (ctl_i.decide) begin
      case (cmd_q)
        CMD_INSERT: begin
          if (found_q) begin
            res_st = ST_DUP;
          end else if (table_full || next_off[OFF_W]) begin
            res_st = ST_FULL;
          end else begin
            res_st    = ST_OK;
            res_slot  = new_slot;
            res_off   = end_off_q;
            ent_we    = 1'b1;
            end_off_d = next_off[OFF_W-1:0];
            if (stack_empty) begin
              used_d = used_q + CW'(1);
            end else begin
              free_top_d = link_rd_q;
            end
          end
        end
        CMD_SEARCH: begin
          if (found_q) begin
            res_st   = ST_OK;
            res_slot = hit_slot_q;
            res_off  = hit_off_q;
          end
        end
        CMD_DELETE: begin
          if (found_q) begin
            res_st     = ST_OK;
            res_slot   = hit_slot_q;
            res_off    = hit_off_q;
            ent_we     = 1'b1;
            ent_wa     = hit_slot_q;
            ent_wd     = {1'b0, key_q, hit_off_q};
            link_we    = 1'b1;
            free_top_d = CW'(hit_slot_q);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q     <= '0;
      pend_q     <= 1'b0;
      last_q     <= 1'b0;
      found_q    <= 1'b0;
      free_top_q <= SlotsC;
      used_q     <= '0;
      end_off_q  <= RESET_OFFSET;
      done_q     <= 1'b0;
    end else begin
      scan_q     <= scan_d;
      pend_q     <= pend_d;
      last_q     <= last_d;
      found_q    <= found_d;
      free_top_q <= free_top_d;
      used_q     <= used_d;
      end_off_q  <= end_off_d;
      done_q     <= ctl_i.decide;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= cmd_i;
      key_q  <= key_i;
      size_q <= FIXED_BYTES + SIZE_W'(name_len_i) + SIZE_W'(surname_len_i)
              + SIZE_W'(course_len_i);
    end
    if (issue) begin
      paddr_q <= scan_q[SW-1:0];
    end
    if (ctl_i.scan && match) begin
      hit_slot_q <= paddr_q;
      hit_off_q  <= ent_rd_q[OFF_W-1:0];
    end
    if (ctl_i.decide) begin
      status_q <= res_st;
      slot_q   <= SLOT_W'(res_slot);
      off_q    <= res_off;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    if (issue) begin
      ent_rd_q <= ent_mem[scan_q[SW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[hit_slot_q] <= free_top_q;
    end
    if (link_re) begin
      link_rd_q <= link_mem[free_top_q[SW-1:0]];
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign slot_o   = slot_q;
  assign offset_o = off_q;

  `KIFS_ASSERT_ALWAYS(a_used_range, used_q <= SlotsC, "fill count beyond table")
  `KIFS_ASSERT_ALWAYS(a_top_range, free_top_q <= SlotsC, "stack top beyond table")
  `KIFS_ASSERT_ALWAYS(a_scan_range, !pend_q || (CW'(paddr_q) < used_q), "scan past fill")
  `KIFS_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "result strobe held")

endmodule

`default_nettype wire

/* hw/rtl/keyed_index_with_free_slot_stack_core.sv */
// A command keeps the core busy through a linear key scan of the slots ever handed out
// from the table end (a hit ends the scan early); with none handed out the scan is skipped.
// The result strobes in the cycle after the decide state. A new word is taken only while idle.
// The busy time is set by the linear key scan, one slot table read per cycle.
// Reset clears the valid fill count, empties the free-slot stack and sets the end offset
// to four; no clearing pass, so a word is taken as soon as reset is released.
// ----------------------------------------------------------------------------
// keyed_index_with_free_slot_stack_core
// Primary-key index with a free-slot stack: insert, search and delete words.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_index_with_free_slot_stack_core import kifs_pkg::*; #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [LEN_W-1:0]  name_len_i,
  input  logic [LEN_W-1:0]  surname_len_i,
  input  logic [LEN_W-1:0]  course_len_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic [OFF_W-1:0]  offset_o
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  kifs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .busy_o (busy_o),
    .ctl_o  (ctl)
  );

  kifs_datapath #(
    .SLOTS(SLOTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .cmd_i        (cmd_i),
    .key_i        (key_i),
    .name_len_i   (name_len_i),
    .surname_len_i(surname_len_i),
    .course_len_i (course_len_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .offset_o     (offset_o)
  );

endmodule

`default_nettype wire

/* tb/tb_keyed_index_with_free_slot_stack_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_index_with_free_slot_stack_core
// Drives insert, search, delete and unused words into the keyed index, with
// random gaps. A local copy of the slot table, free-slot stack and end offset
// predicts each result word the directed table does not give. A short directed
// table comes first, then random traffic with most keys from a small key pool.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_keyed_index_with_free_slot_stack_core;
  import kifs_pkg::*;

  localparam int unsigned SLOTS       = 1024;
  localparam int unsigned RAND_WORDS  = 560;
  localparam int unsigned DRAIN_WAIT  = 1100;
  localparam longint unsigned CYCLE_LIMIT = 64'd8_000_000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX    = 31'h7FFF_FFFF;

  typedef struct packed {
    status_e           st;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  off;
  } idx_rsp_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] nl;
    logic [LEN_W-1:0] sl;
    logic [LEN_W-1:0] cl;
    logic             typed;
    idx_rsp_t         rsp;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 21;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [CMD_W-1:0]  cmd_i;
  logic [KEY_W-1:0]  key_i;
  logic [LEN_W-1:0]  name_len_i;
  logic [LEN_W-1:0]  surname_len_i;
  logic [LEN_W-1:0]  course_len_i;
  logic              done_o;
  logic [1:0]        status_o;
  logic [SLOT_W-1:0] slot_o;
  logic [OFF_W-1:0]  offset_o;

  // predicted index state
  bit                idx_valid [SLOTS];
  logic [KEY_W-1:0]  idx_key   [SLOTS];
  logic [OFF_W-1:0]  idx_off   [SLOTS];
  int unsigned       idx_link  [SLOTS];
  int unsigned       stack_top;
  int unsigned       used_cnt;
  logic [OFF_W-1:0]  end_offset;

  idx_rsp_t          rsp_q [$];
  logic [KEY_W-1:0]  key_pool [$];
  dir_row_t          dir_tbl [DIR_ROWS];
  int unsigned       err_cnt;
  longint unsigned   cycle_cnt;
  bit                idle_on;

  keyed_index_with_free_slot_stack_core #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .key_i        (key_i),
    .name_len_i   (name_len_i),
    .surname_len_i(surname_len_i),
    .course_len_i (course_len_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .offset_o     (offset_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int idx_lookup(input logic [KEY_W-1:0] key);
    for (int i = 0; i < SLOTS; i++) begin
      if (idx_valid[i] && idx_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic idx_rsp_t idx_apply(input logic [CMD_W-1:0] cmd,
                                         input logic [KEY_W-1:0] key,
                                         input logic [LEN_W-1:0] nl,
                                         input logic [LEN_W-1:0] sl,
                                         input logic [LEN_W-1:0] cl);
    idx_rsp_t        r;
    int              hit;
    int unsigned     s;
    longint unsigned nxt;
    r   = '{ST_NOTFOUND, '0, '0};
    hit = idx_lookup(key);
    case (cmd)
      CMD_INSERT: begin
        nxt = longint'(end_offset) + longint'(FIXED_BYTES) + longint'(nl)
              + longint'(sl) + longint'(cl);
        if (hit >= 0) begin
          r.st = ST_DUP;
        end else if (stack_top >= SLOTS && used_cnt >= SLOTS) begin
          r.st = ST_FULL;
        end else if (nxt > 64'hFFFF_FFFF) begin
          r.st = ST_FULL;
        end else begin
          if (stack_top < SLOTS) begin
            s         = stack_top;
            stack_top = idx_link[s];
            if (stack_top > SLOTS) stack_top = SLOTS;
          end else begin
            s        = used_cnt;
            used_cnt = used_cnt + 1;
          end
          idx_valid[s] = 1'b1;
          idx_key[s]   = key;
          idx_off[s]   = end_offset;
          r            = '{ST_OK, SLOT_W'(s), end_offset};
          end_offset   = OFF_W'(nxt);
        end
      end
      CMD_SEARCH: begin
        if (hit >= 0) r = '{ST_OK, SLOT_W'(hit), idx_off[hit]};
      end
      CMD_DELETE: begin
        if (hit >= 0) begin
          idx_valid[hit] = 1'b0;
          idx_link[hit]  = stack_top;
          stack_top      = hit;
          r              = '{ST_OK, SLOT_W'(hit), idx_off[hit]};
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic issue_word(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                            input logic [LEN_W-1:0] nl, input logic [LEN_W-1:0] sl,
                            input logic [LEN_W-1:0] cl, input logic typed,
                            input idx_rsp_t typed_rsp);
    int unsigned gap;
    idx_rsp_t    pred;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i       <= 1'b1;
    cmd_i         <= cmd;
    key_i         <= key;
    name_len_i    <= nl;
    surname_len_i <= sl;
    course_len_i  <= cl;
    do @(posedge clk_i); while (busy_o);
    pred = idx_apply(cmd, key, nl, sl, cl);
    rsp_q.push_back(typed ? typed_rsp : pred);
    if (cmd == CMD_INSERT) begin
      key_pool.push_back(key);
      if (key_pool.size() > 48) void'(key_pool.pop_front());
    end
  endtask

  function automatic logic [LEN_W-1:0] rand_len();
    int unsigned m;
    m = $urandom_range(0, 9);
    if (m == 0) return '0;
    if (m == 1) return '1;
    return LEN_W'($urandom_range(0, 255));
  endfunction

  task automatic issue_random();
    int unsigned      sel;
    int unsigned      k;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    sel = $urandom_range(0, 99);
    if (sel < 42)      cmd = CMD_INSERT;
    else if (sel < 68) cmd = CMD_SEARCH;
    else if (sel < 95) cmd = CMD_DELETE;
    else               cmd = CMD_UNUSED;
    k = $urandom_range(0, 99);
    if (k < 60 && key_pool.size() > 0) key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    else if (k < 85)                   key = KEY_W'($urandom);
    else if (k < 92)                   key = $urandom_range(0, 1) ? KEY_MAX : '0;
    else                               key = KEY_W'($urandom_range(0, 15));
    issue_word(cmd, key, rand_len(), rand_len(), rand_len(), 1'b0, '{ST_OK, '0, '0});
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d result words outstanding", $time, rsp_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    idx_rsp_t want;
    if (rst_ni && done_o) begin
      if (rsp_q.size() == 0) begin
        err_cnt = err_cnt + 1;
        $display("%0t: unexpected result word: status %0d slot %0d offset %0h", $time,
                 status_o, slot_o, offset_o);
      end else begin
        want = rsp_q.pop_front();
        if (status_o !== want.st) begin
          err_cnt = err_cnt + 1;
          $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.st,
                   status_o);
        end
        if (slot_o !== want.slot) begin
          err_cnt = err_cnt + 1;
          $display("%0t: slot mismatch: expected %0d, actual %0d", $time, want.slot, slot_o);
        end
        if (offset_o !== want.off) begin
          err_cnt = err_cnt + 1;
          $display("%0t: offset mismatch: expected %0h, actual %0h", $time, want.off,
                   offset_o);
        end
      end
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    cmd_i         = CMD_SEARCH;
    key_i         = '0;
    name_len_i    = '0;
    surname_len_i = '0;
    course_len_i  = '0;
    err_cnt       = 0;
    cycle_cnt     = 0;
    idle_on       = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      idx_valid[i] = 1'b0;
      idx_key[i]   = '0;
      idx_off[i]   = '0;
      idx_link[i]  = 0;
    end
    stack_top  = SLOTS;
    used_cnt   = 0;
    end_offset = RESET_OFFSET;

    dir_tbl = '{
      '{CMD_SEARCH, 31'd5,         8'd1,   8'd1,   8'd1,   1'b1, '{ST_NOTFOUND, 10'd0, 32'd0}},
      '{CMD_DELETE, 31'd5,         8'd1,   8'd1,   8'd1,   1'b1, '{ST_NOTFOUND, 10'd0, 32'd0}},
      '{CMD_INSERT, 31'd0,         8'd0,   8'd0,   8'd0,   1'b1, '{ST_OK,       10'd0, 32'd4}},
      '{CMD_INSERT, KEY_MAX,       8'd255, 8'd255, 8'd255, 1'b1, '{ST_OK,       10'd1, 32'd24}},
      '{CMD_INSERT, 31'd0,         8'd1,   8'd1,   8'd1,   1'b1, '{ST_DUP,      10'd0, 32'd0}},
      '{CMD_SEARCH, KEY_MAX,       8'd0,   8'd0,   8'd0,   1'b1, '{ST_OK,       10'd1, 32'd24}},
      '{CMD_SEARCH, 31'd0,         8'd0,   8'd0,   8'd0,   1'b1, '{ST_OK,       10'd0, 32'd4}},
      '{CMD_UNUSED, 31'd0,         8'd255, 8'd255, 8'd255, 1'b1, '{ST_NOTFOUND, 10'd0, 32'd0}},
      '{CMD_INSERT, 31'd42,        8'd200, 8'd1,   8'd200, 1'b0, '{ST_OK,       10'd0, 32'd0}},
      '{CMD_DELETE, 31'd0,         8'd0,   8'd0,   8'd0,   1'b1, '{ST_OK,       10'd0, 32'd4}},
      '{CMD_SEARCH, 31'd0,         8'd0,   8'd0,   8'd0,   1'b1, '{ST_NOTFOUND, 10'd0, 32'd0}},
      '{CMD_DELETE, 31'd0,         8'd0,   8'd0,   8'd0,   1'b1, '{ST_NOTFOUND, 10'd0, 32'd0}},
      '{CMD_DELETE, KEY_MAX,       8'd0,   8'd0,   8'd0,   1'b0, '{ST_OK,       10'd0, 32'd0}},
      '{CMD_INSERT, 31'h5555_5555, 8'd1,   8'd2,   8'd3,   1'b0, '{ST_OK,       10'd0, 32'd0}},
      '{CMD_INSERT, 31'h2AAA_AAAA, 8'd128, 8'd64,  8'd32,  1'b0, '{ST_OK,       10'd0, 32'd0}},
      '{CMD_INSERT, 31'd3,         8'd0,   8'd0,   8'd0,   1'b0, '{ST_OK,       10'd0, 32'd0}},
      '{CMD_SEARCH, 31'h2AAA_AAAA, 8'd0,   8'd0,   8'd0,   1'b0, '{ST_OK,       10'd0, 32'd0}},
      '{CMD_DELETE, 31'd42,        8'd0,   8'd0,   8'd0,   1'b0, '{ST_OK,       10'd0, 32'd0}},
      '{CMD_INSERT, 31'd42,        8'd7,   8'd9,   8'd11,  1'b0, '{ST_OK,       10'd0, 32'd0}},
      '{CMD_UNUSED, KEY_MAX,       8'd0,   8'd0,   8'd0,   1'b1, '{ST_NOTFOUND, 10'd0, 32'd0}},
      '{CMD_SEARCH, KEY_MAX,       8'd0,   8'd0,   8'd0,   1'b1, '{ST_NOTFOUND, 10'd0, 32'd0}}
    };

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      issue_word(dir_tbl[r].cmd, dir_tbl[r].key, dir_tbl[r].nl, dir_tbl[r].sl,
                 dir_tbl[r].cl, dir_tbl[r].typed, dir_tbl[r].rsp);
    end

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      issue_random();
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
